FILE: hdl/moving_average_crossover_signal_unit_assert.svh
`ifndef MOVING_AVERAGE_CROSSOVER_SIGNAL_UNIT_ASSERT_SVH
`define MOVING_AVERAGE_CROSSOVER_SIGNAL_UNIT_ASSERT_SVH

// same-cycle implication
`define MACS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MACS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/macs_pkg.sv
package macs_pkg;

    localparam int PRICE_W   = 32;
    localparam int WIN_W     = 7;
    localparam int SUM_W     = 39;
    localparam int PROD_W    = SUM_W + WIN_W;
    localparam int PNL_W     = 33;
    localparam int TOTAL_W   = 48;
    localparam int DIV_CNT_W = 6;
    localparam int CFG_IDX_W = 1;
    localparam int QUEUE_AW  = 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW  = 1'b1;

    localparam logic [WIN_W-1:0] SHORT_WINDOW_RESET = 7'd3;
    localparam logic [WIN_W-1:0] LONG_WINDOW_RESET  = 7'd5;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_BUY  = 2'd1,
        ACT_SELL = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_DIV,
        ST_DECIDE
    } back_state_t;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [WIN_W-1:0]   short_win;
        logic [WIN_W-1:0]   long_win;
        logic               ready;
    } job_t;

endpackage

FILE: hdl/macs_front.sv
module macs_front
    import macs_pkg::*;
#(
    parameter int MAX_WINDOW = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 price_valid,
    output logic                 price_ready,
    input  logic [PRICE_W-1:0]   price,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIN_W-1:0]     cfg_data,
    input  logic                 queue_full,
    output logic                 push,
    output job_t                 push_job
);

    localparam int CW = $clog2(MAX_WINDOW + 1);

    logic [WIN_W-1:0] short_window_reg;
    logic [WIN_W-1:0] long_window_reg;
    logic [CW-1:0]    seen_reg;
    logic [CW-1:0]    seen_next;
    logic [WIN_W-1:0] sw;
    logic [WIN_W-1:0] lw;

    function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] r;
        if (w == '0)
        begin
            r = WIN_W'(1);
        end
        else if (32'(w) > MAX_WINDOW)
        begin
            r = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            r = w;
        end
        return r;
    endfunction

    assign sw = eff_window(short_window_reg);
    assign lw = eff_window(long_window_reg);

    assign price_ready = !queue_full;
    assign push        = price_valid && price_ready;

    always_comb
    begin
        if (32'(seen_reg) >= MAX_WINDOW)
        begin
            seen_next = seen_reg;
        end
        else
        begin
            seen_next = seen_reg + CW'(1);
        end
    end

    always_comb
    begin
        push_job.price     = price;
        push_job.short_win = sw;
        push_job.long_win  = lw;
        push_job.ready     = (32'(seen_next) >= 32'(sw)) && (32'(seen_next) >= 32'(lw));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_window_reg <= SHORT_WINDOW_RESET;
            long_window_reg  <= LONG_WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHORT_WINDOW: short_window_reg <= cfg_data;
                REG_LONG_WINDOW:  long_window_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (push)
        begin
            seen_reg <= seen_next;
        end
    end

endmodule

FILE: hdl/macs_queue.sv
module macs_queue
    import macs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full    = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QUEUE_AW + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QUEUE_AW + 1)'(1);
            end
        end
    end

endmodule

FILE: hdl/macs_div.sv
module macs_div
    import macs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend,
    input  logic [WIN_W-1:0]   divisor,
    output logic               busy,
    output logic [PRICE_W-1:0] quotient
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [WIN_W-1:0]     rem_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [WIN_W-1:0]     div_reg;
    logic [WIN_W:0]       trial;
    logic [WIN_W:0]       diff;
    logic                 ge;
    logic [WIN_W-1:0]     rem_next;

    // restoring divide, one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign ge       = (trial >= {1'b0, div_reg});
    assign diff     = trial - {1'b0, div_reg};
    assign rem_next = ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];

    assign busy     = busy_reg;
    assign quotient = quo_reg[PRICE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SUM_W-2:0], ge};
        end
    end

endmodule

FILE: hdl/macs_back.sv
module macs_back
    import macs_pkg::*;
#(
    parameter int MAX_WINDOW = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     job_valid,
    input  job_t                     job,
    output logic                     job_pop,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic                     ready_res,
    output logic [PRICE_W-1:0]       short_average,
    output logic [PRICE_W-1:0]       long_average,
    output logic [1:0]               action,
    output logic signed [PNL_W-1:0]  trade_pnl,
    output logic signed [TOTAL_W-1:0] total_profit
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    back_state_t state_reg;
    back_state_t state_next;

    logic [PRICE_W-1:0] mem [MAX_WINDOW];
    logic [PRICE_W-1:0] rd_data_reg;

    job_t               job_reg;
    logic [AW-1:0]      wp_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic [WIN_W-1:0]   k_reg;
    logic               pend_reg;
    logic [WIN_W-1:0]   pend_k_reg;
    logic [SUM_W-1:0]   ssum_reg;
    logic [SUM_W-1:0]   lsum_reg;
    logic [PROD_W-1:0]  lhs_reg;
    logic [PROD_W-1:0]  rhs_reg;
    logic               holding_reg;
    logic [PRICE_W-1:0] entry_reg;
    logic signed [TOTAL_W-1:0] total_reg;

    logic                      result_valid_reg;
    logic                      ready_res_reg;
    logic [PRICE_W-1:0]        short_average_reg;
    logic [PRICE_W-1:0]        long_average_reg;
    action_t                   action_reg;
    logic signed [PNL_W-1:0]   trade_pnl_reg;
    logic signed [TOTAL_W-1:0] total_profit_reg;

    logic [WIN_W-1:0]   n_max;
    logic               issue;
    logic               div_start;
    logic               out_load;
    logic               div_busy_s;
    logic               div_busy_l;
    logic [PRICE_W-1:0] quo_s;
    logic [PRICE_W-1:0] quo_l;
    logic               buy;
    logic               sell;
    logic signed [PNL_W-1:0]   pnl;
    logic signed [TOTAL_W:0]   total_sum;
    logic signed [TOTAL_W-1:0] total_sat;

    macs_div u_div_short
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ssum_reg),
        .divisor  (job_reg.short_win),
        .busy     (div_busy_s),
        .quotient (quo_s)
    );

    macs_div u_div_long
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lsum_reg),
        .divisor  (job_reg.long_win),
        .busy     (div_busy_l),
        .quotient (quo_l)
    );

    assign n_max = (job_reg.short_win > job_reg.long_win) ? job_reg.short_win
                                                          : job_reg.long_win;
    assign issue = (state_reg == ST_SUM) && (k_reg != n_max);

    assign buy  = job_reg.ready && !holding_reg && (lhs_reg > rhs_reg);
    assign sell = job_reg.ready && holding_reg && (lhs_reg < rhs_reg);
    assign pnl  = $signed({1'b0, job_reg.price}) - $signed({1'b0, entry_reg});
    assign total_sum = {total_reg[TOTAL_W-1], total_reg}
                     + {{(TOTAL_W + 1 - PNL_W){pnl[PNL_W-1]}}, pnl};

    always_comb
    begin
        if (total_sum[TOTAL_W] != total_sum[TOTAL_W-1])
        begin
            total_sat = total_sum[TOTAL_W] ? {1'b1, {(TOTAL_W - 1){1'b0}}}
                                           : {1'b0, {(TOTAL_W - 1){1'b1}}};
        end
        else
        begin
            total_sat = total_sum[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_pop    = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    state_next = job.ready ? ST_SUM : ST_DECIDE;
                end
            end
            ST_SUM:
            begin
                if ((k_reg == n_max) && !pend_reg)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy_s && !div_busy_l)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // history ring
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            mem[wp_reg] <= job.price;
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
        end
        else if (job_pop)
        begin
            if (32'(wp_reg) == MAX_WINDOW - 1)
            begin
                wp_reg <= '0;
            end
            else
            begin
                wp_reg <= wp_reg + AW'(1);
            end
        end
    end

    // window sums, newest first
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg     <= job;
            rd_addr_reg <= wp_reg;
            k_reg       <= '0;
            ssum_reg    <= '0;
            lsum_reg    <= '0;
        end
        else
        begin
            if (issue)
            begin
                k_reg      <= k_reg + WIN_W'(1);
                pend_k_reg <= k_reg;
                if (rd_addr_reg == '0)
                begin
                    rd_addr_reg <= AW'(MAX_WINDOW - 1);
                end
                else
                begin
                    rd_addr_reg <= rd_addr_reg - AW'(1);
                end
            end
            if (pend_reg)
            begin
                if (pend_k_reg < job_reg.short_win)
                begin
                    ssum_reg <= ssum_reg + SUM_W'(rd_data_reg);
                end
                if (pend_k_reg < job_reg.long_win)
                begin
                    lsum_reg <= lsum_reg + SUM_W'(rd_data_reg);
                end
            end
        end
        if (state_reg == ST_MUL)
        begin
            lhs_reg <= ssum_reg * PROD_W'(job_reg.long_win);
            rhs_reg <= lsum_reg * PROD_W'(job_reg.short_win);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;
        end
    end

    // trade state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg <= 1'b0;
            entry_reg   <= '0;
            total_reg   <= '0;
        end
        else if (out_load)
        begin
            if (buy)
            begin
                holding_reg <= 1'b1;
                entry_reg   <= job_reg.price;
            end
            else if (sell)
            begin
                holding_reg <= 1'b0;
                total_reg   <= total_sat;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ready_res_reg     <= job_reg.ready;
            short_average_reg <= job_reg.ready ? quo_s : '0;
            long_average_reg  <= job_reg.ready ? quo_l : '0;
            trade_pnl_reg     <= sell ? pnl : '0;
            total_profit_reg  <= sell ? total_sat : total_reg;
            if (buy)
            begin
                action_reg <= ACT_BUY;
            end
            else if (sell)
            begin
                action_reg <= ACT_SELL;
            end
            else
            begin
                action_reg <= ACT_NONE;
            end
        end
    end

    assign result_valid  = result_valid_reg;
    assign ready_res     = ready_res_reg;
    assign short_average = short_average_reg;
    assign long_average  = long_average_reg;
    assign action        = action_reg;
    assign trade_pnl     = trade_pnl_reg;
    assign total_profit  = total_profit_reg;

endmodule

FILE: hdl/moving_average_crossover_signal_unit.sv
// channel   direction  handshake                  payload
// price     in         price_valid / price_ready   price
// result    out        result_valid / result_ready ready_res, short_average, long_average,
//                                                  action, trade_pnl, total_profit
// config    in         cfg_we                      cfg_index, cfg_data
//
// an item with both windows full goes from acceptance to the result register through a pop that
// stores the price, a sum sweep over the larger window through the single read port of the history
// ring, a multiply, the divider and a decide step
// an item before the windows fill skips the sum, multiply and divide steps and goes straight to decide
// a two-entry queue takes transactions while the back end works; result register stalls hold it
// reset clears control state only, the history ring needs no clearing pass
module moving_average_crossover_signal_unit
    import macs_pkg::*;
#(
    parameter int MAX_WINDOW = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      price_valid,
    output logic                      price_ready,
    input  logic [PRICE_W-1:0]        price,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [WIN_W-1:0]          cfg_data,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic                      ready_res,
    output logic [PRICE_W-1:0]        short_average,
    output logic [PRICE_W-1:0]        long_average,
    output logic [1:0]                action,
    output logic signed [PNL_W-1:0]   trade_pnl,
    output logic signed [TOTAL_W-1:0] total_profit
);

    logic push;
    job_t push_job;
    logic queue_full;
    logic queue_empty;
    logic pop;
    job_t pop_job;

    macs_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .price_valid (price_valid),
        .price_ready (price_ready),
        .price       (price),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .queue_full  (queue_full),
        .push        (push),
        .push_job    (push_job)
    );

    macs_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (queue_empty)
    );

    macs_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (!queue_empty),
        .job           (pop_job),
        .job_pop       (pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .ready_res     (ready_res),
        .short_average (short_average),
        .long_average  (long_average),
        .action        (action),
        .trade_pnl     (trade_pnl),
        .total_profit  (total_profit)
    );

endmodule

FILE: hdl/macs_checker.sv
`include "moving_average_crossover_signal_unit_assert.svh"

module macs_checker
    import macs_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      result_valid,
    input logic                      result_ready,
    input logic                      ready_res,
    input logic [PRICE_W-1:0]        short_average,
    input logic [PRICE_W-1:0]        long_average,
    input logic [1:0]                action,
    input logic signed [PNL_W-1:0]   trade_pnl,
    input logic signed [TOTAL_W-1:0] total_profit
);

    // nothing reported before the windows fill
    `MACS_ASSERT_NOW(a_not_ready_zero, clk, rst_n, result_valid && !ready_res, short_average == '0 && long_average == '0 && action == ACT_NONE)

    // pnl only on a sell
    `MACS_ASSERT_NOW(a_pnl_only_on_sell, clk, rst_n, result_valid && action != ACT_SELL, trade_pnl == '0)

    // trades only once ready
    `MACS_ASSERT_NOW(a_trade_needs_ready, clk, rst_n, result_valid && (action == ACT_BUY || action == ACT_SELL), ready_res)

    // a stalled transaction holds
    `MACS_ASSERT_NEXT(a_stall_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(total_profit) && $stable(action) && $stable(short_average))

endmodule

bind moving_average_crossover_signal_unit macs_checker u_macs_checker (.*);
